/* rtl/core/ascii85_stream_encoder_top_macros.svh */
// Assertion macros shared by the Ascii85 encoder modules.
`ifndef ASCII85_STREAM_ENCODER_TOP_MACROS_SVH
`define ASCII85_STREAM_ENCODER_TOP_MACROS_SVH
`ifndef SYNTH
// Same-cycle implication, checked at every rising edge out of reset.
`define A85_CHECK(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("a85 same-cycle check failed");
// Next-cycle implication, checked at every rising edge out of reset.
`define A85_CHECK_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("a85 next-cycle check failed");
`else
`define A85_CHECK(label, clk, rst_n, ante, cons)
`define A85_CHECK_NEXT(label, clk, rst_n, ante, cons)
`endif
`endif

/* rtl/core/a85_pkg.sv */
// Types and constants shared by the Ascii85 stream encoder.
package a85_pkg;

    // One input item: a message byte and its end-of-message flag.
    typedef struct packed {
        logic [7:0] data_byte;
        logic       final_byte;
    } in_item_t;

    // One result item: a character and its end markers.
    typedef struct packed {
        logic [6:0] out_char;
        logic       run_end;
        logic       message_end;
    } out_item_t;

    // What the group part of a job turns into.
    typedef enum logic [1:0] {
        BODY_NONE,
        BODY_ZERO,
        BODY_DIGITS
    } body_kind_t;

    // Work handed from the front end to the converter.
    typedef struct packed {
        logic       hdr;
        body_kind_t kind;
        logic [2:0] ndig;
        logic [31:0] value;
        logic       trailer;
    } job_t;

    // Converted work handed from the converter to the emitter.
    // Digits are stored least significant first, already offset.
    typedef struct packed {
        logic            hdr;
        logic            zero;
        logic [2:0]      ndig;
        logic            trailer;
        logic [4:0][6:0] digits;
    } plan_t;

    // Converter states.
    typedef enum logic [1:0] {
        CONV_IDLE,
        CONV_RUN,
        CONV_HOLD
    } conv_state_t;

    // Division by 85 as multiplication by a reciprocal, exact for 32-bit values.
    localparam logic [31:0] RECIP_MULT  = 32'd3233857729;
    localparam int          RECIP_SHIFT = 38;
    localparam logic [31:0] DIGIT_BASE  = 32'd85;
    localparam logic [6:0]  DIGIT_OFFSET = 7'd33;
    localparam logic [2:0]  FULL_DIGITS = 3'd5;

    // Characters.
    localparam logic [6:0] CHAR_Z     = 7'h7A;
    localparam logic [6:0] CHAR_LT    = 7'h3C;
    localparam logic [6:0] CHAR_TILDE = 7'h7E;
    localparam logic [6:0] CHAR_GT    = 7'h3E;

endpackage

/* rtl/core/a85_front.sv */
// Front end: accepts bytes, packs groups and classifies the work per byte.
module a85_front (
    input  logic             clk,
    input  logic             rst_n,
    input  a85_pkg::in_item_t data,
    input  logic             push,
    output logic             full,
    output logic             job_push,
    output a85_pkg::job_t    job,
    input  logic             job_full
);

    logic [23:0] acc_reg, acc_next;
    logic [1:0]  cnt_reg, cnt_next;
    logic        hdr_sent_reg, hdr_sent_next;
    logic        accept;
    logic [31:0] group;
    logic [23:0] acc_after;
    logic [1:0]  cnt_after;

    assign full   = job_full;
    assign accept = push && !job_full;
    assign group  = {acc_reg, data.data_byte};

    // Classify the byte and work out the next group state.
    always_comb
    begin
        job.hdr     = !hdr_sent_reg;
        job.kind    = a85_pkg::BODY_NONE;
        job.ndig    = 3'd0;
        job.value   = 32'd0;
        job.trailer = data.final_byte;
        acc_after   = {acc_reg[15:0], data.data_byte};
        cnt_after   = cnt_reg + 2'd1;
        if (cnt_reg == 2'd3)
        begin
            job.kind  = (group == 32'd0) ? a85_pkg::BODY_ZERO : a85_pkg::BODY_DIGITS;
            job.ndig  = a85_pkg::FULL_DIGITS;
            job.value = group;
            acc_after = 24'd0;
            cnt_after = 2'd0;
        end
        acc_next      = acc_after;
        cnt_next      = cnt_after;
        hdr_sent_next = 1'b1;
        if (data.final_byte)
        begin
            // A pending partial group is flushed as r+1 digits.
            if (cnt_after != 2'd0)
            begin
                job.kind  = a85_pkg::BODY_DIGITS;
                job.ndig  = {1'b0, cnt_after} + 3'd1;
                job.value = {8'd0, acc_after};
            end
            acc_next      = 24'd0;
            cnt_next      = 2'd0;
            hdr_sent_next = 1'b0;
        end
        job_push = accept && (job.hdr || job.trailer || (job.kind != a85_pkg::BODY_NONE));
    end

    // Group state.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            acc_reg      <= 24'd0;
            cnt_reg      <= 2'd0;
            hdr_sent_reg <= 1'b0;
        end
        else if (accept)
        begin
            acc_reg      <= acc_next;
            cnt_reg      <= cnt_next;
            hdr_sent_reg <= hdr_sent_next;
        end
    end

endmodule

/* rtl/core/a85_queue.sv */
// Two-entry job queue between the front end and the converter.
module a85_queue (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          wr_en,
    input  a85_pkg::job_t wr_job,
    output logic          full,
    output logic          rd_valid,
    output a85_pkg::job_t rd_job,
    input  logic          rd_en
);

    a85_pkg::job_t entry_reg [2];
    logic       wr_ptr_reg;
    logic       rd_ptr_reg;
    logic [1:0] count_reg, count_next;
    logic       do_wr;
    logic       do_rd;

    assign full     = (count_reg == 2'd2);
    assign rd_valid = (count_reg != 2'd0);
    assign rd_job   = entry_reg[rd_ptr_reg];
    assign do_wr    = wr_en && !full;
    assign do_rd    = rd_en && rd_valid;

    // Occupancy follows pushes and pops.
    always_comb
    begin
        count_next = count_reg;
        if (do_wr && !do_rd)
        begin
            count_next = count_reg + 2'd1;
        end
        else if (do_rd && !do_wr)
        begin
            count_next = count_reg - 2'd1;
        end
    end

    // Pointers and occupancy.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end
        else
        begin
            count_reg <= count_next;
            if (do_wr)
            begin
                wr_ptr_reg <= !wr_ptr_reg;
            end
            if (do_rd)
            begin
                rd_ptr_reg <= !rd_ptr_reg;
            end
        end
    end

    // Entry storage.
    always_ff @(posedge clk)
    begin
        if (do_wr)
        begin
            entry_reg[wr_ptr_reg] <= wr_job;
        end
    end

endmodule

/* rtl/core/a85_conv.sv */
// Converter: turns a group value into base-85 digits, one digit per cycle.
`include "ascii85_stream_encoder_top_macros.svh"
module a85_conv (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           job_valid,
    input  a85_pkg::job_t  job,
    output logic           job_pop,
    output logic           plan_valid,
    output a85_pkg::plan_t plan,
    input  logic           plan_take
);

    a85_pkg::conv_state_t state_reg, state_next;
    logic            hdr_reg;
    logic            zero_reg;
    logic [2:0]      ndig_reg;
    logic            trailer_reg;
    logic [31:0]     val_reg;
    logic [63:0]     prod_reg;
    logic [2:0]      cnt_reg;
    logic [4:0][6:0] dig_reg;
    logic            load;
    logic            run;
    logic [31:0]     quot;
    logic [31:0]     rem_wide;
    logic [6:0]      digit;

    // Quotient from the registered product; remainder by multiply and subtract.
    assign quot     = {6'd0, prod_reg[63:a85_pkg::RECIP_SHIFT]};
    assign rem_wide = val_reg - 32'(quot * a85_pkg::DIGIT_BASE);
    assign digit    = rem_wide[6:0] + a85_pkg::DIGIT_OFFSET;

    // State register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= a85_pkg::CONV_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    // Next state and handshake outputs.
    always_comb
    begin
        state_next = state_reg;
        load       = 1'b0;
        run        = 1'b0;
        plan_valid = 1'b0;
        case (state_reg)
            a85_pkg::CONV_IDLE:
            begin
                load = job_valid;
            end
            a85_pkg::CONV_RUN:
            begin
                run = 1'b1;
                if (cnt_reg == ndig_reg - 3'd1)
                begin
                    state_next = a85_pkg::CONV_HOLD;
                end
            end
            a85_pkg::CONV_HOLD:
            begin
                plan_valid = 1'b1;
                if (plan_take)
                begin
                    load       = job_valid;
                    state_next = a85_pkg::CONV_IDLE;
                end
            end
            default:
            begin
                state_next = a85_pkg::CONV_IDLE;
            end
        endcase
        if (load)
        begin
            state_next = (job.kind == a85_pkg::BODY_DIGITS) ? a85_pkg::CONV_RUN
                                                            : a85_pkg::CONV_HOLD;
        end
        job_pop = load;
    end

    // Datapath: load a job, then peel off one digit per cycle.
    always_ff @(posedge clk)
    begin
        if (load)
        begin
            hdr_reg     <= job.hdr;
            zero_reg    <= (job.kind == a85_pkg::BODY_ZERO);
            ndig_reg    <= (job.kind == a85_pkg::BODY_DIGITS) ? job.ndig : 3'd0;
            trailer_reg <= job.trailer;
            val_reg     <= job.value;
            prod_reg    <= {32'd0, job.value} * {32'd0, a85_pkg::RECIP_MULT};
            cnt_reg     <= 3'd0;
        end
        else if (run)
        begin
            dig_reg[cnt_reg] <= digit;
            val_reg          <= quot;
            prod_reg         <= {32'd0, quot} * {32'd0, a85_pkg::RECIP_MULT};
            cnt_reg          <= cnt_reg + 3'd1;
        end
    end

    assign plan.hdr     = hdr_reg;
    assign plan.zero    = zero_reg;
    assign plan.ndig    = ndig_reg;
    assign plan.trailer = trailer_reg;
    assign plan.digits  = dig_reg;

    // The digit counter never runs past the digit count of the job.
    `A85_CHECK(a_run_range, clk, rst_n, state_reg == a85_pkg::CONV_RUN, cnt_reg < ndig_reg)
    // A plan is only taken while one is held.
    `A85_CHECK(a_take_hold, clk, rst_n, plan_take, state_reg == a85_pkg::CONV_HOLD)

endmodule

/* rtl/core/a85_emit.sv */
// Emitter: lays out a plan as characters and hands them out one per cycle while the reader pops.
`include "ascii85_stream_encoder_top_macros.svh"
module a85_emit (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               plan_valid,
    input  a85_pkg::plan_t     plan,
    output logic               plan_take,
    input  logic               pop,
    output logic               empty,
    output a85_pkg::out_item_t result
);

    logic [6:0] chars_reg [7];
    logic [6:0] built [7];
    logic [2:0] cnt_reg;
    logic       msg_reg;
    logic       pop_ok;
    logic [3:0] hoff;
    logic [3:0] blen;
    logic [3:0] total;
    logic [3:0] rel;
    logic [2:0] idx;

    assign empty     = (cnt_reg == 3'd0);
    assign pop_ok    = pop && !empty;
    assign plan_take = plan_valid && (empty || ((cnt_reg == 3'd1) && pop_ok));

    assign result.out_char    = chars_reg[0];
    assign result.run_end     = (cnt_reg == 3'd1);
    assign result.message_end = (cnt_reg == 3'd1) && msg_reg;

    // Place header, body and trailer characters into their slots.
    always_comb
    begin
        hoff  = plan.hdr ? 4'd2 : 4'd0;
        blen  = plan.zero ? 4'd1 : {1'b0, plan.ndig};
        total = hoff + blen + (plan.trailer ? 4'd2 : 4'd0);
        rel   = 4'd0;
        idx   = 3'd0;
        for (int i = 0; i < 7; i++)
        begin
            rel = 4'(i) - hoff;
            idx = 3'(blen - 4'd1 - rel);
            if (4'(i) < hoff)
            begin
                built[i] = (i == 0) ? a85_pkg::CHAR_LT : a85_pkg::CHAR_TILDE;
            end
            else if (rel < blen)
            begin
                built[i] = plan.zero ? a85_pkg::CHAR_Z : plan.digits[idx];
            end
            else if (rel == blen)
            begin
                built[i] = a85_pkg::CHAR_TILDE;
            end
            else
            begin
                built[i] = a85_pkg::CHAR_GT;
            end
        end
    end

    // Character count and end-of-message flag.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg <= 3'd0;
            msg_reg <= 1'b0;
        end
        else if (plan_take)
        begin
            cnt_reg <= total[2:0];
            msg_reg <= plan.trailer;
        end
        else if (pop_ok)
        begin
            cnt_reg <= cnt_reg - 3'd1;
        end
    end

    // Character line: load a whole plan, shift by one on each pop.
    always_ff @(posedge clk)
    begin
        if (plan_take)
        begin
            chars_reg <= built;
        end
        else if (pop_ok)
        begin
            for (int i = 0; i < 6; i++)
            begin
                chars_reg[i] <= chars_reg[i + 1];
            end
        end
    end

    // A taken plan always leaves characters to hand out.
    `A85_CHECK_NEXT(a_take_fills, clk, rst_n, plan_take, cnt_reg != 3'd0)
    // A pop without a new plan drops exactly one character.
    `A85_CHECK_NEXT(a_pop_drains, clk, rst_n, pop_ok && !plan_take, cnt_reg == $past(cnt_reg) - 3'd1)
    // The message end marker only sits on the closing character.
    `A85_CHECK(a_end_char, clk, rst_n, !empty && result.message_end, result.out_char == a85_pkg::CHAR_GT)

endmodule

/* rtl/core/ascii85_stream_encoder_top.sv */
// Flow: an accepted byte that yields work is written to the job queue as a job; the converter
// loads it, peels off its digits if it has any, and holds the plan until the emitter takes it.
// Overlap: the converter loads a new job only once its plan has been taken, and the emitter
// takes a plan when it is empty or as its last character is popped.
// Reset: asynchronous, active low; clears group state, the job queue and both back-end units.
// Top level of the Ascii85 stream encoder.
module ascii85_stream_encoder_top (
    input  logic               clk,
    input  logic               rst_n,
    input  a85_pkg::in_item_t  data,
    input  logic               push,
    output logic               full,
    output a85_pkg::out_item_t result,
    output logic               empty,
    input  logic               pop
);

    logic           job_push;
    a85_pkg::job_t  job_in;
    logic           job_full;
    logic           job_valid;
    a85_pkg::job_t  job_out;
    logic           job_pop;
    logic           plan_valid;
    a85_pkg::plan_t plan;
    logic           plan_take;

    // Byte intake and group packing.
    a85_front u_front (
        .clk      (clk),
        .rst_n    (rst_n),
        .data     (data),
        .push     (push),
        .full     (full),
        .job_push (job_push),
        .job      (job_in),
        .job_full (job_full)
    );

    // Decoupling queue.
    a85_queue u_queue (
        .clk      (clk),
        .rst_n    (rst_n),
        .wr_en    (job_push),
        .wr_job   (job_in),
        .full     (job_full),
        .rd_valid (job_valid),
        .rd_job   (job_out),
        .rd_en    (job_pop)
    );

    // Base-85 conversion.
    a85_conv u_conv (
        .clk        (clk),
        .rst_n      (rst_n),
        .job_valid  (job_valid),
        .job        (job_out),
        .job_pop    (job_pop),
        .plan_valid (plan_valid),
        .plan       (plan),
        .plan_take  (plan_take)
    );

    // Character output.
    a85_emit u_emit (
        .clk        (clk),
        .rst_n      (rst_n),
        .plan_valid (plan_valid),
        .plan       (plan),
        .plan_take  (plan_take),
        .pop        (pop),
        .empty      (empty),
        .result     (result)
    );

endmodule
